// ===== sv/uoc_pkg.sv =====
// uoc_pkg: types, constants and codes for the utility ordered cache
// used by uoc_cell and utility_ordered_cache; no other dependencies
package uoc_pkg;

    localparam int unsigned DefaultCapacity = 64;
    localparam int unsigned CapWidth = 7;
    localparam logic [2:0] ClassLimit = 3'd4;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_REFRESH = 3'd1,
        ST_INSERT  = 3'd2,
        ST_REPLACE = 3'd3,
        ST_DROP    = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_CAPACITY = 1'b0,
        REG_ENABLE   = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] key;
        logic [31:0] payload;
        logic [31:0] utility;
        logic [2:0]  fetch_class;
    } in_word_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_payload;
        logic [2:0]  update_status;
        logic        evicted_valid;
        logic [31:0] evicted_key;
    } out_word_t;

    // candidate travelling along the chain during the scan
    typedef struct packed {
        logic        found;     // key match seen upstream
        logic        has_free;  // free slot seen upstream
        logic        has_min;   // some valid entry seen upstream
        logic [31:0] min_util;
        logic [31:0] min_key;
        logic [31:0] hit_payload;
    } chain_t;

    // write command broadcast to all cells
    typedef struct packed {
        logic        lookup_mark; // set used on matching entry
        logic        refresh;     // refresh utility on matching entry
        logic        insert;      // write into first free cell
        logic        replace;     // overwrite least cell
        logic [31:0] key;
        logic [31:0] payload;
        logic [31:0] utility;
        logic [2:0]  fetch_class;
    } wr_cmd_t;

endpackage

// ===== sv/uoc_cell.sv =====
// uoc_cell: one cache entry plus its link in the comparison chain
// depends on uoc_pkg
module uoc_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     key,
    input  uoc_pkg::chain_t chain_in,
    output uoc_pkg::chain_t chain_out,
    input  logic            first_free_in,  // no free cell upstream
    output logic            first_free_out,
    input  logic            is_least,       // chosen by the final compare
    input  uoc_pkg::wr_cmd_t wr,
    output logic            valid,
    output logic            match,
    output logic [31:0]     ent_key,
    output logic [31:0]     ent_util
);
    import uoc_pkg::*;

    logic        valid_reg;
    logic [31:0] key_reg, pay_reg, util_reg;
    logic [1:0]  class_reg;
    logic        used_reg;
    logic        better;
    chain_t      c;

    assign match = valid_reg && (key_reg == key);
    assign valid = valid_reg;
    assign ent_key = key_reg;
    assign ent_util = util_reg;

    assign better = !chain_in.has_min || (util_reg < chain_in.min_util) ||
                    ((util_reg == chain_in.min_util) && (key_reg < chain_in.min_key));

    always_comb
    begin
        c = chain_in;
        if (match)
        begin
            c.found = 1'b1;
            c.hit_payload = pay_reg;
        end
        if (!valid_reg)
            c.has_free = 1'b1;
        if (valid_reg && better)
        begin
            c.has_min = 1'b1;
            c.min_util = util_reg;
            c.min_key = key_reg;
        end
    end
    // registered hand-off to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain_out <= '0;
        else
            chain_out <= c;
    end

    assign first_free_out = first_free_in && valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (wr.insert && first_free_in && !valid_reg)
            valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if ((wr.insert && first_free_in && !valid_reg) || (wr.replace && is_least))
        begin
            key_reg   <= wr.key;
            pay_reg   <= wr.payload;
            util_reg  <= wr.utility;
            class_reg <= wr.fetch_class[1:0];
            used_reg  <= 1'b0;
        end
        else if (wr.refresh && match)
        begin
            util_reg <= wr.utility;
            if (wr.fetch_class != 3'd0)
            begin
                class_reg <= wr.fetch_class[1:0];
                used_reg  <= 1'b0;
            end
        end
        else if (wr.lookup_mark && match)
            used_reg <= 1'b1;
    end
endmodule

// ===== sv/utility_ordered_cache.sv =====
// utility_ordered_cache: top level, control sequencer and cell chain
// depends on uoc_pkg and uoc_cell
//
// fully associative cache built as a chain of CAPACITY cells. each word in
// passes through the scan, apply and output states before the next word
// can be accepted: in the scan the key match, free-slot and least-utility
// candidate ripple one cell per cycle down the registered chain, in the
// apply state the chosen cell is decided and written, and in the output
// state the result sits in the output register, where it stays while
// out_ready is low. the chain length sets the latency. a new word is
// accepted once the previous result has been taken or is leaving.
// configuration writes take effect at once and belong between words.
module utility_ordered_cache #(
    parameter int unsigned CAPACITY = uoc_pkg::DefaultCapacity
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  uoc_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output uoc_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data
);
    import uoc_pkg::*;

    localparam int unsigned CntW = $clog2(CAPACITY + 1);
    localparam int unsigned FillW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;
    in_word_t word_reg;
    out_word_t out_reg, out_next;
    logic [CntW-1:0] cnt_reg;
    logic [FillW-1:0] fill_reg;
    logic [CapWidth-1:0] cap_reg;
    logic en_reg;
    logic [FillW-1:0] eff_cap;

    chain_t chain [CAPACITY+1];
    logic   ffree [CAPACITY+1];
    logic [CAPACITY-1:0] vld, mtc, least;
    logic [31:0] ekey [CAPACITY];
    logic [31:0] eutil [CAPACITY];
    wr_cmd_t wr;
    chain_t res;
    logic upd_ok;

    assign chain[0] = '0;
    assign ffree[0] = 1'b1;
    assign res = chain[CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            uoc_cell u_cell (
                .clk(clk), .rst_n(rst_n), .key(word_reg.key),
                .chain_in(chain[g]), .chain_out(chain[g+1]),
                .first_free_in(ffree[g]), .first_free_out(ffree[g+1]),
                .is_least(least[g]), .wr(wr), .valid(vld[g]), .match(mtc[g]),
                .ent_key(ekey[g]), .ent_util(eutil[g])
            );
            // least entry is unique: keys are distinct among valid cells
            assign least[g] = vld[g] && (ekey[g] == res.min_key) &&
                              (eutil[g] == res.min_util);
        end
    endgenerate

    // effective capacity: 0 acts as 1, above CAPACITY clamps
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = FillW'(1);
        else if (32'(cap_reg) > CAPACITY)
            eff_cap = FillW'(CAPACITY);
        else
            eff_cap = FillW'(cap_reg);
    end

    assign upd_ok = en_reg && (word_reg.fetch_class < ClassLimit);

    // state transitions
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_SCAN;
            S_SCAN:  if (cnt_reg == CntW'(CAPACITY - 1)) state_next = S_APPLY;
            S_APPLY: state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = in_valid ? S_SCAN : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // decision and write command
    always_comb
    begin
        wr = '0;
        wr.key = word_reg.key;
        wr.payload = word_reg.payload;
        wr.utility = word_reg.utility;
        wr.fetch_class = word_reg.fetch_class;
        out_next = '0;
        unique case (state_reg)
            S_APPLY:
            begin
                if (!word_reg.cmd)
                begin
                    wr.lookup_mark = res.found;
                    out_next.hit = res.found;
                    out_next.read_payload = res.found ? res.hit_payload : 32'd0;
                    out_next.update_status = ST_NONE;
                end
                else if (!upd_ok)
                    out_next.update_status = ST_NONE;
                else if (res.found)
                begin
                    wr.refresh = 1'b1;
                    out_next.update_status = ST_REFRESH;
                end
                else if ((fill_reg < eff_cap) && res.has_free)
                begin
                    wr.insert = 1'b1;
                    out_next.update_status = ST_INSERT;
                end
                else if (res.has_min && (word_reg.utility > res.min_util))
                begin
                    wr.replace = 1'b1;
                    out_next.update_status = ST_REPLACE;
                    out_next.evicted_valid = 1'b1;
                    out_next.evicted_key = res.min_key;
                end
                else
                    out_next.update_status = ST_DROP;
            end
            default: out_next = out_reg;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && out_ready);
    assign out_valid = (state_reg == S_OUT);
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            cap_reg   <= CapWidth'(64);
            en_reg    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= (state_reg == S_SCAN) ? cnt_reg + CntW'(1) : '0;
            if (wr.insert)
                fill_reg <= fill_reg + FillW'(1);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CAPACITY: cap_reg <= cfg_data;
                    REG_ENABLE:   en_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            word_reg <= in_data;
        out_reg <= out_next;
    end

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({wr.insert, wr.replace, wr.refresh, wr.lookup_mark}) <= 1)
        else $error("more than one write kind at once");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FillW'(CAPACITY))
        else $error("fill count above capacity");
    a_least_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        wr.replace |-> $onehot(least))
        else $error("replacement target not unique");
    a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(mtc))
        else $error("duplicate key in cache");
    a_out_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> out_valid)
        else $error("result not presented");
endmodule
